@@ hw/rtl/psdu_pkg.sv @@
// Shared constants for the point to shape distance unit.
package psdu_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int OP_W   = 3;
   localparam int DIST_W = 32;
   localparam int DSQ_W  = 64;

   localparam logic [OP_W-1:0] OP_POINT   = 3'd0;
   localparam logic [OP_W-1:0] OP_LINE    = 3'd1;
   localparam logic [OP_W-1:0] OP_SEGMENT = 3'd2;
   localparam logic [OP_W-1:0] OP_CIRCLE  = 3'd3;
   localparam logic [OP_W-1:0] OP_STADIUM = 3'd4;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [DSQ_W-1:0]  DSQ_MAX  = '1;

endpackage

@@ hw/rtl/point_shape_distance_unit.sv @@
// Point to shape distance unit: pipelined distance and squared distance, Q16.16.
//
// Request channel (req_*): one query point plus one shape per transfer; the
// operation selects point, line, segment, circle or stadium. Response channel
// (rsp_*): one result per request, in request order, with distance, squared
// distance and the invalid flag (degenerate line or unused operation code).
// Throughput is one transfer per cycle while req_stall is low. The pipeline
// holds a restoring divider (one quotient bit per stage, QW stages) and the
// square root that follows it (one root bit per stage, QW/2 stages), with
// QW = max(2*COORD_WIDTH+2, 64).
// Reset clears all valid bits; no item is in flight afterwards and no
// clearing pass is needed.
// The output has a response register and one skid register. While the
// receiver stalls, the pipeline keeps going until the skid register fills;
// then req_stall goes high and the whole pipeline holds. req_stall is a
// register output and has no path from rsp_stall.
module point_shape_distance_unit #(
   parameter int COORD_WIDTH = psdu_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = psdu_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [psdu_pkg::OP_W-1:0]          req_operation,
   input  logic signed [COORD_WIDTH-1:0]      req_query_x,
   input  logic signed [COORD_WIDTH-1:0]      req_query_y,
   input  logic signed [COORD_WIDTH-1:0]      req_start_x,
   input  logic signed [COORD_WIDTH-1:0]      req_start_y,
   input  logic signed [COORD_WIDTH-1:0]      req_end_x,
   input  logic signed [COORD_WIDTH-1:0]      req_end_y,
   input  logic [COORD_WIDTH-2:0]             req_shape_radius,
   input  logic signed [COORD_WIDTH-1:0]      req_coef_a,
   input  logic signed [COORD_WIDTH-1:0]      req_coef_b,
   input  logic signed [COORD_WIDTH-1:0]      req_coef_c,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [psdu_pkg::DIST_W-1:0]        rsp_distance_value,
   output logic [psdu_pkg::DSQ_W-1:0]         rsp_distance_squared,
   output logic                               rsp_invalid
);
   import psdu_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int DFW = W + 1;
   localparam int PRW = 2 * DFW;
   localparam int SMW = PRW + 1;
   localparam int MW  = SMW;
   localparam int LW  = MW / 2;
   localparam int HW  = MW - LW;
   localparam int NW  = 2 * MW;
   localparam int QW  = (2 * W + 2 > DSQ_W) ? 2 * W + 2 : DSQ_W;
   localparam int DNW = PRW;
   localparam int HIW = NW - QW;
   localparam int CW  = (HIW > DNW) ? HIW : DNW;
   localparam int RW  = QW / 2;
   localparam int RMW = RW + 2;
   localparam int XW  = ((RW > DIST_W) ? RW : DIST_W) + 1;
   localparam int EW  = QW + 1;

   typedef struct packed {
      logic [DNW-1:0] rem;
      logic [QW-1:0]  bits;
      logic [DNW-1:0] den;
      logic           ovf;
      logic           inval;
      logic           sub_rad;
      logic [W-2:0]   rad;
   } dv_type;

   typedef struct packed {
      logic [QW-1:0]  d2;
      logic [RMW-1:0] rem;
      logic [RW-1:0]  root;
      logic           ovf;
      logic           inval;
      logic           sub_rad;
      logic [W-2:0]   rad;
   } sq_type;

   typedef struct packed {
      logic [DIST_W-1:0] dval;
      logic [DSQ_W-1:0]  dsq;
      logic              inval;
   } res_type;

   logic en;
   logic skid_valid_ff;
   logic rsp_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: operand differences; a line maps a,b onto v and the query onto w
   logic                  s1_valid_ff;
   logic [OP_W-1:0]       s1_op_ff;
   logic [W-2:0]          s1_rad_ff;
   logic signed [W-1:0]   s1_c_ff;
   logic signed [DFW-1:0] s1_vx_ff, s1_vy_ff, s1_wx_ff, s1_wy_ff, s1_ux_ff, s1_uy_ff;
   logic signed [DFW-1:0] s1_vx_in, s1_vy_in, s1_wx_in, s1_wy_in, s1_ux_in, s1_uy_in;
   logic signed [DFW-1:0] qx, qy, sx, sy, ex, ey, ca, cb;
   logic                  req_line;

   always_comb begin
      qx = {req_query_x[W-1], req_query_x};
      qy = {req_query_y[W-1], req_query_y};
      sx = {req_start_x[W-1], req_start_x};
      sy = {req_start_y[W-1], req_start_y};
      ex = {req_end_x[W-1], req_end_x};
      ey = {req_end_y[W-1], req_end_y};
      ca = {req_coef_a[W-1], req_coef_a};
      cb = {req_coef_b[W-1], req_coef_b};
      req_line = (req_operation == OP_LINE);
      s1_vx_in = req_line ? ca : ex - sx;
      s1_vy_in = req_line ? cb : ey - sy;
      s1_wx_in = req_line ? qx : qx - sx;
      s1_wy_in = req_line ? qy : qy - sy;
      s1_ux_in = qx - ex;
      s1_uy_in = qy - ey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff  <= req_operation;
         s1_rad_ff <= req_shape_radius;
         s1_c_ff   <= req_coef_c;
         s1_vx_ff  <= s1_vx_in;
         s1_vy_ff  <= s1_vy_in;
         s1_wx_ff  <= s1_wx_in;
         s1_wy_ff  <= s1_wy_in;
         s1_ux_ff  <= s1_ux_in;
         s1_uy_ff  <= s1_uy_in;
      end
   end

   // stage 2: products
   logic                  s2_valid_ff;
   logic [OP_W-1:0]       s2_op_ff;
   logic [W-2:0]          s2_rad_ff;
   logic signed [W-1:0]   s2_c_ff;
   logic signed [PRW-1:0] s2_d1a_ff, s2_d1b_ff, s2_d2a_ff, s2_d2b_ff, s2_cra_ff, s2_crb_ff;
   logic signed [PRW-1:0] s2_wxx_ff, s2_wyy_ff, s2_uxx_ff, s2_uyy_ff, s2_vxx_ff, s2_vyy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_op_ff  <= s1_op_ff;
         s2_rad_ff <= s1_rad_ff;
         s2_c_ff   <= s1_c_ff;
         s2_d1a_ff <= s1_vx_ff * s1_wx_ff;
         s2_d1b_ff <= s1_vy_ff * s1_wy_ff;
         s2_d2a_ff <= s1_vx_ff * s1_ux_ff;
         s2_d2b_ff <= s1_vy_ff * s1_uy_ff;
         s2_cra_ff <= s1_wx_ff * s1_vy_ff;
         s2_crb_ff <= s1_wy_ff * s1_vx_ff;
         s2_wxx_ff <= s1_wx_ff * s1_wx_ff;
         s2_wyy_ff <= s1_wy_ff * s1_wy_ff;
         s2_uxx_ff <= s1_ux_ff * s1_ux_ff;
         s2_uyy_ff <= s1_uy_ff * s1_uy_ff;
         s2_vxx_ff <= s1_vx_ff * s1_vx_ff;
         s2_vyy_ff <= s1_vy_ff * s1_vy_ff;
      end
   end

   // stage 3: sums
   logic                  s3_valid_ff;
   logic [OP_W-1:0]       s3_op_ff;
   logic [W-2:0]          s3_rad_ff;
   logic signed [SMW-1:0] s3_dot1_ff, s3_dot2_ff, s3_cross_ff;
   logic [PRW-1:0]        s3_w2_ff, s3_u2_ff, s3_v2_ff;
   logic signed [SMW-1:0] s3_dot1_in, c_sh;

   always_comb begin
      c_sh       = SMW'(s2_c_ff) <<< F;
      s3_dot1_in = SMW'(s2_d1a_ff) + SMW'(s2_d1b_ff);
      if (s2_op_ff == OP_LINE) begin
         s3_dot1_in = s3_dot1_in + c_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_op_ff    <= s2_op_ff;
         s3_rad_ff   <= s2_rad_ff;
         s3_dot1_ff  <= s3_dot1_in;
         s3_dot2_ff  <= SMW'(s2_d2a_ff) + SMW'(s2_d2b_ff);
         s3_cross_ff <= SMW'(s2_cra_ff) - SMW'(s2_crb_ff);
         s3_w2_ff    <= $unsigned(s2_wxx_ff) + $unsigned(s2_wyy_ff);
         s3_u2_ff    <= $unsigned(s2_uxx_ff) + $unsigned(s2_uyy_ff);
         s3_v2_ff    <= $unsigned(s2_vxx_ff) + $unsigned(s2_vyy_ff);
      end
   end

   // stage 4: case select, magnitude of the numerator
   logic                  s4_valid_ff;
   logic                  s4_sub_rad_ff, s4_inval_ff, s4_use_div_ff;
   logic [W-2:0]          s4_rad_ff;
   logic [PRW-1:0]        s4_direct_ff;
   logic [MW-1:0]         s4_mag_ff;
   logic [DNW-1:0]        s4_den_ff;
   logic                  s4_inval_in, s4_use_div_in;
   logic [PRW-1:0]        s4_direct_in;
   logic signed [SMW-1:0] sel;

   always_comb begin
      s4_inval_in   = 1'b0;
      s4_use_div_in = 1'b0;
      s4_direct_in  = '0;
      sel           = s3_cross_ff;
      unique case (s3_op_ff)
         OP_POINT, OP_CIRCLE: begin
            s4_direct_in = s3_w2_ff;
         end
         OP_SEGMENT, OP_STADIUM: begin
            if (s3_dot1_ff[SMW-1] || (s3_dot1_ff == '0)) begin
               s4_direct_in = s3_w2_ff;
            end else if (!s3_dot2_ff[SMW-1]) begin
               s4_direct_in = s3_u2_ff;
            end else begin
               s4_use_div_in = 1'b1;
            end
         end
         OP_LINE: begin
            sel = s3_dot1_ff;
            if (s3_v2_ff == '0) begin
               s4_inval_in = 1'b1;
            end else begin
               s4_use_div_in = 1'b1;
            end
         end
         default: begin
            s4_inval_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_sub_rad_ff <= (s3_op_ff == OP_CIRCLE) || (s3_op_ff == OP_STADIUM);
         s4_rad_ff     <= s3_rad_ff;
         s4_inval_ff   <= s4_inval_in;
         s4_use_div_ff <= s4_use_div_in;
         s4_direct_ff  <= s4_direct_in;
         s4_mag_ff     <= sel[SMW-1] ? $unsigned(-sel) : $unsigned(sel);
         s4_den_ff     <= s3_v2_ff;
      end
   end

   // stage 5: partial products of the numerator square
   logic                   s5_valid_ff;
   logic                   s5_sub_rad_ff, s5_inval_ff, s5_use_div_ff;
   logic [W-2:0]           s5_rad_ff;
   logic [PRW-1:0]         s5_direct_ff;
   logic [DNW-1:0]         s5_den_ff;
   logic [2*HW-1:0]        s5_hh_ff;
   logic [HW+LW-1:0]       s5_hl_ff;
   logic [2*LW-1:0]        s5_ll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_sub_rad_ff <= s4_sub_rad_ff;
         s5_rad_ff     <= s4_rad_ff;
         s5_inval_ff   <= s4_inval_ff;
         s5_use_div_ff <= s4_use_div_ff;
         s5_direct_ff  <= s4_direct_ff;
         s5_den_ff     <= s4_den_ff;
         s5_hh_ff      <= s4_mag_ff[MW-1:LW] * s4_mag_ff[MW-1:LW];
         s5_hl_ff      <= s4_mag_ff[MW-1:LW] * s4_mag_ff[LW-1:0];
         s5_ll_ff      <= s4_mag_ff[LW-1:0] * s4_mag_ff[LW-1:0];
      end
   end

   // stage 6: dividend and divisor; direct cases divide by one
   logic                   s6_valid_ff;
   logic                   s6_sub_rad_ff, s6_inval_ff;
   logic [W-2:0]           s6_rad_ff;
   logic [NW-1:0]          s6_num_ff;
   logic [DNW-1:0]         s6_den_ff;
   logic [NW-1:0]          sq_num;

   assign sq_num = (NW'(s5_hh_ff) << (2 * LW)) + (NW'(s5_hl_ff) << (LW + 1)) + NW'(s5_ll_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_sub_rad_ff <= s5_sub_rad_ff;
         s6_rad_ff     <= s5_rad_ff;
         s6_inval_ff   <= s5_inval_ff;
         s6_num_ff     <= s5_use_div_ff ? sq_num : NW'(s5_direct_ff);
         s6_den_ff     <= s5_use_div_ff ? s5_den_ff : DNW'(1);
      end
   end

   // divider: entry stage checks for quotient overflow, then one bit a stage
   dv_type         dv_ff [0:QW];
   logic           dv_valid_ff [0:QW];
   dv_type         dv0_in;
   logic [CW-1:0]  num_hi;

   always_comb begin
      num_hi         = CW'(s6_num_ff[NW-1:QW]);
      dv0_in.rem     = num_hi[DNW-1:0];
      dv0_in.bits    = s6_num_ff[QW-1:0];
      dv0_in.den     = s6_den_ff;
      dv0_in.ovf     = (num_hi >= CW'(s6_den_ff));
      dv0_in.inval   = s6_inval_ff;
      dv0_in.sub_rad = s6_sub_rad_ff;
      dv0_in.rad     = s6_rad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [DNW:0] t;
      logic         ge;
      dv_type       dv_in;

      always_comb begin
         t          = {dv_ff[k-1].rem, dv_ff[k-1].bits[QW-1]};
         ge         = (t >= {1'b0, dv_ff[k-1].den});
         dv_in      = dv_ff[k-1];
         dv_in.rem  = ge ? DNW'(t - {1'b0, dv_ff[k-1].den}) : t[DNW-1:0];
         dv_in.bits = {dv_ff[k-1].bits[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k] <= dv_in;
         end
      end
   end

   // square root: two radicand bits and one root bit a stage
   sq_type sq_ff [1:RW];
   logic   sq_valid_ff [1:RW];

   for (genvar j = 1; j <= RW; j++) begin : g_sqrt
      localparam int P = QW - 2 * j;
      sq_type         src;
      logic           src_valid;
      logic [RMW+1:0] t;
      logic [RMW-1:0] trial;
      logic           ge;
      sq_type         sq_in;

      if (j == 1) begin : g_first
         always_comb begin
            src.d2      = dv_ff[QW].bits;
            src.rem     = '0;
            src.root    = '0;
            src.ovf     = dv_ff[QW].ovf;
            src.inval   = dv_ff[QW].inval;
            src.sub_rad = dv_ff[QW].sub_rad;
            src.rad     = dv_ff[QW].rad;
            src_valid   = dv_valid_ff[QW];
         end
      end else begin : g_next
         always_comb begin
            src       = sq_ff[j-1];
            src_valid = sq_valid_ff[j-1];
         end
      end

      always_comb begin
         t          = {src.rem, src.d2[P+1:P]};
         trial      = {src.root, 2'b01};
         ge         = (t >= (RMW+2)'(trial));
         sq_in      = src;
         sq_in.rem  = ge ? RMW'(t - (RMW+2)'(trial)) : t[RMW-1:0];
         sq_in.root = {src.root[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j] <= sq_in;
         end
      end
   end

   // radius, saturation
   res_type       push_data;
   logic [XW-1:0] dx, rx;
   logic [EW-1:0] d2x;
   logic          push, pop;

   always_comb begin
      dx  = XW'(sq_ff[RW].root);
      rx  = XW'(sq_ff[RW].rad);
      d2x = EW'(sq_ff[RW].d2);
      if (sq_ff[RW].sub_rad) begin
         dx = (dx > rx) ? dx - rx : '0;
      end
      if (sq_ff[RW].ovf || (dx > XW'(DIST_MAX))) begin
         push_data.dval = DIST_MAX;
      end else begin
         push_data.dval = dx[DIST_W-1:0];
      end
      if (sq_ff[RW].ovf || (d2x > EW'(DSQ_MAX))) begin
         push_data.dsq = DSQ_MAX;
      end else begin
         push_data.dsq = d2x[DSQ_W-1:0];
      end
      push_data.inval = sq_ff[RW].inval;
   end

   assign push = en && sq_valid_ff[RW];
   assign pop  = rsp_valid_ff && !rsp_stall;

   // response register plus skid
   res_type rsp_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || pop) begin
         rsp_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || pop) begin
         rsp_ff <= push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_distance_value   = rsp_ff.dval;
   assign rsp_distance_squared = rsp_ff.dsq;
   assign rsp_invalid          = rsp_ff.inval;

`ifndef SYNTHESIS
   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a response");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while response was free");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled response dropped");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.inval) |-> (rsp_ff.dval == '0 && rsp_ff.dsq == '0))
      else $error("invalid result carries a distance");
`endif

endmodule
